// ===== hw/rtl/rotary_encoder_button_interface_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Rotary encoder button interface - assertion macros
// Concurrent assertion wrappers on clk / arst_n, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_INTERFACE_UNIT_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_INTERFACE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define REB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define REB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define REB_ASSERT_SAME(label, ante, cons)
`define REB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/reb_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder button interface - package
// Beat types, configuration codes and reset values.
// ----------------------------------------------------------------------------
package reb_pkg;

	localparam int OFFSET_WIDTH_DEF = 16;
	localparam int TIME_WIDTH_DEF   = 32;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 16;

	localparam logic [15:0] SPM_RST     = 16'd1000;
	localparam logic [7:0]  CHECKS_RST  = 8'd5;
	localparam logic [15:0] LOCKOUT_RST = 16'd5;
	localparam logic [15:0] HOLD_RST    = 16'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLES_PER_MS,
		CFG_DEBOUNCE_CHECKS,
		CFG_LOCKOUT_MS,
		CFG_HOLD_THRESHOLD_MS
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] samples_per_ms;
		logic [7:0]  debounce_checks;
		logic [15:0] lockout_ms;
		logic [15:0] hold_threshold_ms;
	} cfg_t;

	typedef struct packed {
		logic chan_a;
		logic chan_b;
		logic button_level;
		logic clear_offset;
		logic clear_clicks;
	} in_t;

	typedef struct packed {
		logic signed [15:0] knob_offset;
		logic               knob_changed;
		logic [15:0]        click_count;
		logic               button_down;
		logic               hold_active;
		logic [31:0]        held_ms;
	} out_t;

endpackage

// ===== hw/rtl/reb_cfg.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder button interface - configuration registers
// Decodes the write port into the four setting registers.
// ----------------------------------------------------------------------------
module reb_cfg
	import reb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_ms    <= SPM_RST;
			cfg_q.debounce_checks   <= CHECKS_RST;
			cfg_q.lockout_ms        <= LOCKOUT_RST;
			cfg_q.hold_threshold_ms <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SAMPLES_PER_MS:    cfg_q.samples_per_ms    <= cfg_data;
				CFG_DEBOUNCE_CHECKS:   cfg_q.debounce_checks   <= cfg_data[7:0];
				CFG_LOCKOUT_MS:        cfg_q.lockout_ms        <= cfg_data;
				CFG_HOLD_THRESHOLD_MS: cfg_q.hold_threshold_ms <= cfg_data;
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/reb_core.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder button interface - state core
// Holds knob, button and timer state; reports it and steps it once per beat.
// ----------------------------------------------------------------------------
`include "rotary_encoder_button_interface_unit_macros.svh"

module reb_core
	import reb_pkg::*;
#(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
	parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  in_t  item,
	input  cfg_t cfg,
	output out_t result
);

	localparam logic signed [OFFSET_WIDTH-1:0] OFF_MAX = {1'b0, {(OFFSET_WIDTH-1){1'b1}}};
	localparam logic signed [OFFSET_WIDTH-1:0] OFF_MIN = {1'b1, {(OFFSET_WIDTH-1){1'b0}}};
	localparam logic signed [OFFSET_WIDTH-1:0] OFF_ONE = OFFSET_WIDTH'(1);
	localparam logic [TIME_WIDTH-1:0]          T_MAX   = '1;
	localparam logic [TIME_WIDTH-1:0]          T_ONE   = TIME_WIDTH'(1);

	logic signed [OFFSET_WIDTH-1:0] off_q, off_d;
	logic                           chg_q, chg_d;
	logic [15:0]                    clicks_q, clicks_d;
	logic                           pressed_q, pressed_d;
	logic [TIME_WIDTH-1:0]          press_q, press_d;
	logic [TIME_WIDTH-1:0]          last_hold_q, last_hold_d;
	logic [TIME_WIDTH-1:0]          since_q, since_d;
	logic [15:0]                    pre_q, pre_d;
	logic                           busy_q, busy_d;
	logic                           dir_q, dir_d;
	logic [7:0]                     left_q, left_d;
	logic [1:0]                     prev_q, prev_d;

	logic [15:0]           spm_eff;
	logic                  tick;
	logic                  accept;
	logic                  acc_dir;
	logic                  ok;
	logic                  fa;
	logic                  fb;
	logic [TIME_WIDTH-1:0] hold_ext;

	assign spm_eff  = (cfg.samples_per_ms == '0) ? 16'd1 : cfg.samples_per_ms;
	assign tick     = ({1'b0, pre_q} + 17'd1) >= {1'b0, spm_eff};
	assign hold_ext = TIME_WIDTH'(cfg.hold_threshold_ms);

	always_comb begin
		pre_d       = tick ? '0 : pre_q + 16'd1;
		since_d     = since_q;
		press_d     = press_q;
		if (tick) begin
			since_d = (since_q == T_MAX) ? since_q : since_q + T_ONE;
			if (pressed_q)
				press_d = (press_q == T_MAX) ? press_q : press_q + T_ONE;
		end

		off_d       = item.clear_offset ? '0 : off_q;
		chg_d       = item.clear_offset ? 1'b0 : chg_q;
		clicks_d    = item.clear_clicks ? '0 : clicks_q;

		busy_d      = busy_q;
		dir_d       = dir_q;
		left_d      = left_q;
		accept      = 1'b0;
		acc_dir     = dir_q;
		ok          = dir_q ? (!item.chan_b && item.chan_a) : (!item.chan_a && item.chan_b);
		fa          = prev_q[0] && !item.chan_a;
		fb          = prev_q[1] && !item.chan_b;

		if (busy_q) begin
			if (!ok) begin
				busy_d = 1'b0;
			end else begin
				left_d = left_q - 8'd1;
				if (left_d == '0)
					accept = 1'b1;
			end
		end else if (since_d >= TIME_WIDTH'(cfg.lockout_ms)) begin
			if (fa || fb) begin
				dir_d   = !fa;
				acc_dir = !fa;
				if (cfg.debounce_checks == '0) begin
					accept = 1'b1;
				end else begin
					busy_d = 1'b1;
					left_d = cfg.debounce_checks;
				end
			end
		end

		if (accept) begin
			if (acc_dir) begin
				if (off_d != OFF_MIN)
					off_d = off_d - OFF_ONE;
			end else begin
				if (off_d != OFF_MAX)
					off_d = off_d + OFF_ONE;
			end
			chg_d   = 1'b1;
			since_d = '0;
			busy_d  = 1'b0;
		end

		pressed_d   = pressed_q;
		last_hold_d = last_hold_q;
		if (!item.button_level && !pressed_q) begin
			pressed_d = 1'b1;
			press_d   = '0;
		end else if (item.button_level && pressed_q) begin
			pressed_d = 1'b0;
			if (press_d < hold_ext) begin
				if (clicks_d != 16'hFFFF)
					clicks_d = clicks_d + 16'd1;
			end else begin
				last_hold_d = press_d;
			end
		end

		prev_d = {item.chan_b, item.chan_a};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			chg_q       <= 1'b0;
			clicks_q    <= '0;
			pressed_q   <= 1'b0;
			press_q     <= '0;
			last_hold_q <= '0;
			since_q     <= '0;
			pre_q       <= '0;
			busy_q      <= 1'b0;
			dir_q       <= 1'b0;
			left_q      <= '0;
			prev_q      <= 2'b11;
		end else if (fire) begin
			off_q       <= off_d;
			chg_q       <= chg_d;
			clicks_q    <= clicks_d;
			pressed_q   <= pressed_d;
			press_q     <= press_d;
			last_hold_q <= last_hold_d;
			since_q     <= since_d;
			pre_q       <= pre_d;
			busy_q      <= busy_d;
			dir_q       <= dir_d;
			left_q      <= left_d;
			prev_q      <= prev_d;
		end
	end

	always_comb begin
		result.knob_offset  = 16'(off_q);
		result.knob_changed = chg_q;
		result.click_count  = clicks_q;
		result.button_down  = pressed_q;
		result.hold_active  = pressed_q && (press_q >= hold_ext);
		result.held_ms      = pressed_q ? 32'(press_q) : 32'(last_hold_q);
	end

	`REB_ASSERT_SAME(a_busy_has_checks, busy_q, left_q != '0)
	`REB_ASSERT_NEXT(a_clear_offset, fire && item.clear_offset, off_q == '0 || chg_q)
	`REB_ASSERT_NEXT(a_press_start, fire && !pressed_q && !item.button_level,
		pressed_q && press_q == '0)

endmodule

// ===== hw/rtl/rotary_encoder_button_interface_unit.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder button interface - top level
// Debounced knob detents and click/hold classification, one sample per beat.
// ----------------------------------------------------------------------------
// One sample beat is accepted every cycle unless the output stalls. A beat
// lands in the input register, the state core reports the state as it stood
// before that sample and steps it in the same cycle, and the report appears
// in the output register; the input and result registers sit around the
// single-pass state update. Both registers advance together, so a full
// output register that is being taken still lets a new beat in.
module rotary_encoder_button_interface_unit
	import reb_pkg::*;
#(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
	parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	out_t result;
	in_t  item_s1;
	out_t out_s2;
	logic valid_s1;
	logic valid_s2;
	logic advance;

	reb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	reb_core #(
		.OFFSET_WIDTH (OFFSET_WIDTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (advance)
			out_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

endmodule
